>>> design/itp_pkg.sv
// Package for the integer text parser: character codes, register indexes
// and the character classification word shared by the parser modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;

	localparam int RADIX_W = 6;
	localparam int VALUE_W = 64;
	localparam int OUT_OFFSET_W = 16;

	localparam logic [RADIX_W-1:0] BASE_AUTO = 6'd0;
	localparam logic [RADIX_W-1:0] BASE_OCT  = 6'd8;
	localparam logic [RADIX_W-1:0] BASE_DEC  = 6'd10;
	localparam logic [RADIX_W-1:0] BASE_HEX  = 6'd16;

	localparam logic REG_RADIX  = 1'b0;
	localparam logic REG_SIGNED = 1'b1;

	typedef struct packed {
		logic       is_space;
		logic       is_plus;
		logic       is_minus;
		logic       is_zero;
		logic       is_x;
		logic       is_dec;
		logic       is_hex_alpha;
		logic [3:0] digit;
	} itp_char_t;

endpackage

`default_nettype wire

>>> design/itp_if.sv
// Handshake interfaces for the integer text parser: the character input
// channel and the result channel. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface itp_in_if;
	logic       valid;
	logic       ready;
	logic       start_req;
	logic [7:0] char_code;

	modport source (output valid, output start_req, output char_code, input ready);
	modport sink (input valid, input start_req, input char_code, output ready);
endinterface

interface itp_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;
	logic [15:0] end_offset;
	logic        finished;

	modport source (output valid, output value, output end_offset, output finished,
		input ready);
	modport sink (input valid, input value, input end_offset, input finished,
		output ready);
endinterface

`default_nettype wire

>>> design/itp_char_class.sv
// Character classifier: decodes one text byte into the flags and digit value
// the parser needs. Depends on itp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itp_char_class (
	input  wire logic [7:0]        char_code,
	output itp_pkg::itp_char_t     cls
);

	logic [7:0] dec_off;
	logic [7:0] lo_off;
	logic [7:0] up_off;
	logic       is_lo;
	logic       is_up;

	always_comb begin
		dec_off = char_code - itp_pkg::CH_ZERO;
		lo_off  = char_code - itp_pkg::CH_LO_A + 8'd10;
		up_off  = char_code - itp_pkg::CH_UP_A + 8'd10;
		is_lo   = (char_code >= itp_pkg::CH_LO_A) && (char_code <= itp_pkg::CH_LO_F);
		is_up   = (char_code >= itp_pkg::CH_UP_A) && (char_code <= itp_pkg::CH_UP_F);

		cls.is_space = (char_code == itp_pkg::CH_SPACE) || (char_code == itp_pkg::CH_TAB) ||
			(char_code == itp_pkg::CH_LF);
		cls.is_plus      = (char_code == itp_pkg::CH_PLUS);
		cls.is_minus     = (char_code == itp_pkg::CH_MINUS);
		cls.is_zero      = (char_code == itp_pkg::CH_ZERO);
		cls.is_x         = (char_code == itp_pkg::CH_LO_X) || (char_code == itp_pkg::CH_UP_X);
		cls.is_dec       = (char_code >= itp_pkg::CH_ZERO) && (char_code <= itp_pkg::CH_NINE);
		cls.is_hex_alpha = is_lo || is_up;

		if (cls.is_dec) begin
			cls.digit = dec_off[3:0];
		end else if (is_lo) begin
			cls.digit = lo_off[3:0];
		end else if (is_up) begin
			cls.digit = up_off[3:0];
		end else begin
			cls.digit = 4'd0;
		end
	end

endmodule

`default_nettype wire

>>> design/itp_parser.sv
// Parser state and single-pass next-state logic: whitespace, sign, prefix and
// digit phases, the accumulator and the consumed count. Depends on itp_pkg
// and itp_char_class.
`timescale 1ns / 1ps
`default_nettype none

module itp_parser #(
	parameter int OFFSET_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                step,
	input  wire logic                                start_req,
	input  wire logic [7:0]                          char_code,
	input  wire logic [itp_pkg::RADIX_W-1:0]         radix,
	input  wire logic                                signed_mode,
	output logic      [itp_pkg::VALUE_W-1:0]         value,
	output logic      [itp_pkg::OUT_OFFSET_W-1:0]    end_offset,
	output logic                                     finished
);

	localparam logic [2:0] PH_LEAD   = 3'd0;
	localparam logic [2:0] PH_WS2    = 3'd1;
	localparam logic [2:0] PH_PREFIX = 3'd2;
	localparam logic [2:0] PH_ZERO   = 3'd3;
	localparam logic [2:0] PH_DIGITS = 3'd4;

	localparam logic [OFFSET_BITS-1:0] CONS_MAX = '1;

	logic [2:0]                      phase_q;
	logic [itp_pkg::VALUE_W-1:0]     acc_q;
	logic                            neg_q;
	logic [itp_pkg::RADIX_W-1:0]     base_q;
	logic [OFFSET_BITS-1:0]          cons_q;
	logic                            stop_q;

	logic [2:0]                      ph;
	logic [itp_pkg::VALUE_W-1:0]     acc;
	logic                            neg;
	logic [itp_pkg::RADIX_W-1:0]     base;
	logic [OFFSET_BITS-1:0]          cons;
	logic                            stp;
	logic                            take;
	logic                            done;
	logic                            digit_ok;
	logic [itp_pkg::VALUE_W-1:0]     acc_mul;
	logic [31:0]                     cons_ext;
	itp_pkg::itp_char_t              cls;

	itp_char_class u_class (
		.char_code (char_code),
		.cls       (cls)
	);

	always_comb begin
		if (start_req) begin
			ph   = PH_LEAD;
			acc  = '0;
			neg  = 1'b0;
			base = '0;
			cons = '0;
			stp  = 1'b0;
		end else begin
			ph   = phase_q;
			acc  = acc_q;
			neg  = neg_q;
			base = base_q;
			cons = cons_q;
			stp  = stop_q;
		end
		take     = 1'b0;
		done     = stp;
		digit_ok = 1'b0;
		acc_mul  = '0;

		if (!done && ph == PH_LEAD) begin
			if (cls.is_space) begin
				take = 1'b1;
				done = 1'b1;
			end else if (signed_mode) begin
				if (cls.is_minus) begin
					neg  = 1'b1;
					take = 1'b1;
					done = 1'b1;
				end else if (cls.is_plus) begin
					take = 1'b1;
					done = 1'b1;
				end
				ph = PH_WS2;
			end else begin
				if (cls.is_plus) begin
					take = 1'b1;
					done = 1'b1;
				end
				ph = PH_PREFIX;
			end
		end

		if (!done && ph == PH_WS2) begin
			if (cls.is_space) begin
				take = 1'b1;
				done = 1'b1;
			end else begin
				if (cls.is_plus) begin
					take = 1'b1;
					done = 1'b1;
				end
				ph = PH_PREFIX;
			end
		end

		if (!done && ph == PH_PREFIX) begin
			base = radix;
			if ((radix == itp_pkg::BASE_AUTO || radix == itp_pkg::BASE_HEX) && cls.is_zero) begin
				take = 1'b1;
				done = 1'b1;
				ph   = PH_ZERO;
			end else begin
				if (radix == itp_pkg::BASE_AUTO) begin
					base = itp_pkg::BASE_DEC;
				end
				ph = PH_DIGITS;
			end
		end

		// After a lone '0' a non-x byte falls through as a digit of the chosen base.
		if (!done && ph == PH_ZERO) begin
			if (cls.is_x) begin
				take = 1'b1;
				done = 1'b1;
				base = itp_pkg::BASE_HEX;
			end else begin
				base = (base == itp_pkg::BASE_AUTO) ? itp_pkg::BASE_OCT : itp_pkg::BASE_HEX;
				acc  = '0;
			end
			ph = PH_DIGITS;
		end

		if (!done) begin
			digit_ok = (cls.is_dec || (base == itp_pkg::BASE_HEX && cls.is_hex_alpha)) &&
				({2'b00, cls.digit} < base);
			if (digit_ok) begin
				acc_mul = acc * {{(itp_pkg::VALUE_W-itp_pkg::RADIX_W){1'b0}}, base};
				acc     = acc_mul + {{(itp_pkg::VALUE_W-4){1'b0}}, cls.digit};
				take    = 1'b1;
			end else begin
				stp = 1'b1;
			end
		end

		if (take && cons != CONS_MAX) begin
			cons = cons + 1'b1;
		end

		value      = neg ? (~acc + 1'b1) : acc;
		cons_ext   = 32'(cons);
		end_offset = (|cons_ext[31:itp_pkg::OUT_OFFSET_W]) ? '1 :
			cons_ext[itp_pkg::OUT_OFFSET_W-1:0];
		finished   = stp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			base_q  <= '0;
			cons_q  <= '0;
			stop_q  <= 1'b0;
		end else if (step) begin
			phase_q <= ph;
			acc_q   <= acc;
			neg_q   <= neg;
			base_q  <= base;
			cons_q  <= cons;
			stop_q  <= stp;
		end
	end

endmodule

`default_nettype wire

>>> design/integer_text_parser.sv
// Integer text parser, top level: input register, configuration registers,
// parser and result register. Depends on itp_pkg, itp_if and itp_parser.
//
// The parser takes one text byte per word and returns one result word per
// byte: the running value (two's complement when a minus sign was taken),
// the count of consumed characters (saturating) and a finished flag. A byte
// with start_req set begins a new string. Throughput is one byte per clock
// while results are taken. An accepted byte is held in the input register
// and its result is captured in the result register, which drives the output:
// one stage in the input register and one in the result register. While a
// result waits, the input register holds its byte and input ready stays low
// until the result is taken, so at most two words are in flight. The
// per-byte path is the 64-bit by 6-bit multiply-add of the accumulator.
// The user must write radix and signed_mode through the configuration port
// only while no byte is in flight; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module integer_text_parser #(
	parameter int OFFSET_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	itp_in_if.sink                           in_ch,
	itp_out_if.source                        out_ch,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [itp_pkg::RADIX_W-1:0] cfg_wdata
);

	logic                                  valid_s1;
	logic                                  start_s1;
	logic [7:0]                            char_s1;
	logic                                  out_valid_q;
	logic [itp_pkg::VALUE_W-1:0]           value_q;
	logic [itp_pkg::OUT_OFFSET_W-1:0]      offset_q;
	logic                                  finished_q;
	logic [itp_pkg::RADIX_W-1:0]           radix_q;
	logic                                  signed_q;
	logic                                  advance;
	logic [itp_pkg::VALUE_W-1:0]           value_nx;
	logic [itp_pkg::OUT_OFFSET_W-1:0]      offset_nx;
	logic                                  finished_nx;

	// A word moves from the input register once the result register is free
	// or being emptied in the same cycle.
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	assign out_ch.valid      = out_valid_q;
	assign out_ch.value      = value_q;
	assign out_ch.end_offset = offset_q;
	assign out_ch.finished   = finished_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q  <= itp_pkg::BASE_DEC;
			signed_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				itp_pkg::REG_RADIX:  radix_q  <= cfg_wdata;
				itp_pkg::REG_SIGNED: signed_q <= cfg_wdata[0];
				default:             radix_q  <= radix_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			start_s1 <= in_ch.start_req;
			char_s1  <= in_ch.char_code;
		end
	end

	itp_parser #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.start_req   (start_s1),
		.char_code   (char_s1),
		.radix       (radix_q),
		.signed_mode (signed_q),
		.value       (value_nx),
		.end_offset  (offset_nx),
		.finished    (finished_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			value_q    <= value_nx;
			offset_q   <= offset_nx;
			finished_q <= finished_nx;
		end
	end

endmodule

`default_nettype wire

>>> tb/sv/integer_text_parser_test.sv
// Self-checking testbench for integer_text_parser: drives text bytes and
// configuration writes, predicts each result word and checks it field by field.
// Depends on itp_pkg, itp_if and the integer_text_parser RTL.
`timescale 1ns / 1ps

module integer_text_parser_test;

	localparam int OFFSET_BITS = 16;
	localparam int STALL_LIMIT = 2000;
	localparam int IDLE_PCT = 38;
	localparam logic [7:0] CH_NUL = 8'h00;

	typedef enum logic [2:0] {
		SCAN_LEAD,
		SCAN_WS2,
		SCAN_PREFIX,
		SCAN_ZERO,
		SCAN_DIGITS
	} scan_phase_t;

	typedef struct packed {
		logic       start;
		logic [7:0] code;
	} text_byte_t;

	typedef struct packed {
		logic [63:0] value;
		logic [15:0] end_offset;
		logic        finished;
	} parse_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic drv_valid = 1'b0;
	logic drv_start = 1'b0;
	logic [7:0] drv_char = 8'h00;
	logic rx_ready = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = itp_pkg::REG_RADIX;
	logic [itp_pkg::RADIX_W-1:0] cfg_wdata = '0;

	int idle_pct = IDLE_PCT;
	int errors = 0;
	int stall_cycles = 0;
	logic next_start = 1'b1;
	text_byte_t char_queue[$];
	parse_result_t pending_results[$];

	// Shadow of the configuration registers and of the parser state.
	logic [itp_pkg::RADIX_W-1:0] shadow_radix = itp_pkg::BASE_DEC;
	logic shadow_signed = 1'b0;
	scan_phase_t scan_phase = SCAN_LEAD;
	logic [63:0] acc_value = '0;
	logic minus_taken = 1'b0;
	logic [itp_pkg::RADIX_W-1:0] digit_base = '0;
	logic [OFFSET_BITS-1:0] char_count = '0;
	logic halted = 1'b0;

	itp_in_if in_ch ();
	itp_out_if out_ch ();

	assign in_ch.valid = drv_valid;
	assign in_ch.start_req = drv_start;
	assign in_ch.char_code = drv_char;
	assign out_ch.ready = rx_ready;

	integer_text_parser #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic is_blank(input logic [7:0] c);
		return c == itp_pkg::CH_SPACE || c == itp_pkg::CH_TAB || c == itp_pkg::CH_LF;
	endfunction

	function automatic void count_char();
		if (char_count != {OFFSET_BITS{1'b1}})
			char_count = char_count + 1'b1;
	endfunction

	// One byte through the scanner; each phase falls through to the next when
	// the byte does not belong to it.
	function automatic void parse_char(input logic [7:0] c);
		logic [itp_pkg::RADIX_W-1:0] d;
		logic ok;
		if (scan_phase == SCAN_LEAD) begin
			if (is_blank(c)) begin
				count_char();
				return;
			end
			if (shadow_signed && c == itp_pkg::CH_MINUS) begin
				minus_taken = 1'b1;
				count_char();
				scan_phase = SCAN_WS2;
				return;
			end
			if (c == itp_pkg::CH_PLUS) begin
				count_char();
				scan_phase = shadow_signed ? SCAN_WS2 : SCAN_PREFIX;
				return;
			end
			scan_phase = shadow_signed ? SCAN_WS2 : SCAN_PREFIX;
		end
		if (scan_phase == SCAN_WS2) begin
			if (is_blank(c)) begin
				count_char();
				return;
			end
			if (c == itp_pkg::CH_PLUS) begin
				count_char();
				scan_phase = SCAN_PREFIX;
				return;
			end
			scan_phase = SCAN_PREFIX;
		end
		if (scan_phase == SCAN_PREFIX) begin
			digit_base = shadow_radix;
			if ((digit_base == itp_pkg::BASE_AUTO || digit_base == itp_pkg::BASE_HEX) &&
				c == itp_pkg::CH_ZERO) begin
				count_char();
				scan_phase = SCAN_ZERO;
				return;
			end
			if (digit_base == itp_pkg::BASE_AUTO)
				digit_base = itp_pkg::BASE_DEC;
			scan_phase = SCAN_DIGITS;
		end
		if (scan_phase == SCAN_ZERO) begin
			if (c == itp_pkg::CH_LO_X || c == itp_pkg::CH_UP_X) begin
				count_char();
				digit_base = itp_pkg::BASE_HEX;
				scan_phase = SCAN_DIGITS;
				return;
			end
			// The zero already counted stands as a digit of value zero.
			digit_base = (digit_base == itp_pkg::BASE_AUTO) ? itp_pkg::BASE_OCT :
				itp_pkg::BASE_HEX;
			acc_value = '0;
			scan_phase = SCAN_DIGITS;
		end
		ok = 1'b1;
		d = '0;
		if (c >= itp_pkg::CH_ZERO && c <= itp_pkg::CH_NINE)
			d = itp_pkg::RADIX_W'(c - itp_pkg::CH_ZERO);
		else if (digit_base == itp_pkg::BASE_HEX && c >= itp_pkg::CH_LO_A &&
			c <= itp_pkg::CH_LO_F)
			d = itp_pkg::RADIX_W'(c - itp_pkg::CH_LO_A + 8'd10);
		else if (digit_base == itp_pkg::BASE_HEX && c >= itp_pkg::CH_UP_A &&
			c <= itp_pkg::CH_UP_F)
			d = itp_pkg::RADIX_W'(c - itp_pkg::CH_UP_A + 8'd10);
		else
			ok = 1'b0;
		if (!ok || d >= digit_base) begin
			halted = 1'b1;
			return;
		end
		acc_value = acc_value * 64'(digit_base) + 64'(d);
		count_char();
	endfunction

	function automatic parse_result_t next_parse_result(input logic start, input logic [7:0] c);
		parse_result_t r;
		if (start) begin
			scan_phase = SCAN_LEAD;
			acc_value = '0;
			minus_taken = 1'b0;
			digit_base = '0;
			char_count = '0;
			halted = 1'b0;
		end
		if (!halted)
			parse_char(c);
		r.value = minus_taken ? -acc_value : acc_value;
		r.end_offset = (char_count > 16'hFFFF) ? 16'hFFFF : 16'(char_count);
		r.finished = halted;
		return r;
	endfunction

	task automatic put_char(input logic [7:0] c);
		text_byte_t b;
		b.start = next_start;
		b.code = c;
		char_queue.push_back(b);
		next_start = 1'b0;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_char(s[i]);
	endtask

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(2))
			0: return itp_pkg::CH_SPACE;
			1: return itp_pkg::CH_TAB;
			default: return itp_pkg::CH_LF;
		endcase
	endfunction

	function automatic logic [7:0] pick_digit(input logic [itp_pkg::RADIX_W-1:0] base);
		string hex_chars = "0123456789abcdefABCDEF";
		if (base == itp_pkg::BASE_HEX)
			return hex_chars[$urandom_range(21)];
		if (base >= itp_pkg::BASE_DEC)
			return itp_pkg::CH_ZERO + 8'($urandom_range(9));
		return itp_pkg::CH_ZERO + 8'($urandom_range(base - 1));
	endfunction

	// Mostly well-formed numbers with random content; about one in ten strings
	// is pure noise and some digits are replaced by random bytes.
	task automatic add_number(input logic [itp_pkg::RADIX_W-1:0] rdx, input logic sgn);
		logic [itp_pkg::RADIX_W-1:0] eff;
		int n;
		next_start = 1'b1;
		if ($urandom_range(9) == 0) begin
			n = $urandom_range(1, 6);
			repeat (n) put_char(8'($urandom_range(255)));
			return;
		end
		repeat ($urandom_range(2)) put_char(pick_blank());
		if ($urandom_range(2) == 0)
			put_char($urandom_range(1) ? itp_pkg::CH_MINUS : itp_pkg::CH_PLUS);
		if (sgn && $urandom_range(3) == 0) begin
			repeat ($urandom_range(2)) put_char(pick_blank());
			if ($urandom_range(1))
				put_char(itp_pkg::CH_PLUS);
		end
		eff = (rdx == itp_pkg::BASE_AUTO) ? itp_pkg::BASE_DEC : rdx;
		if ((rdx == itp_pkg::BASE_AUTO || rdx == itp_pkg::BASE_HEX) &&
			$urandom_range(2) == 0) begin
			put_char(itp_pkg::CH_ZERO);
			if ($urandom_range(3) != 0) begin
				put_char($urandom_range(1) ? itp_pkg::CH_LO_X : itp_pkg::CH_UP_X);
				eff = itp_pkg::BASE_HEX;
			end else if (rdx == itp_pkg::BASE_AUTO) begin
				eff = itp_pkg::BASE_OCT;
			end
		end
		// Long runs make the accumulator wrap.
		n = ($urandom_range(7) == 0) ? $urandom_range(14, 24) : $urandom_range(0, 8);
		repeat (n) put_char(($urandom_range(11) == 0) ? 8'($urandom_range(255)) : pick_digit(eff));
		put_char($urandom_range(1) ? CH_NUL : 8'($urandom_range(255)));
		repeat ($urandom_range(1)) put_char(8'($urandom_range(255)));
	endtask

	// Checked at the falling edge, where every update of the rising edge has
	// settled, so a word just taken from the queue is already on the bus.
	task automatic drain_results();
		while (char_queue.size() != 0 || drv_valid || pending_results.size() != 0)
			@(negedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_regs(input logic [itp_pkg::RADIX_W-1:0] rdx, input logic sgn);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= itp_pkg::REG_RADIX;
		cfg_wdata <= rdx;
		shadow_radix = rdx;
		@(posedge clk);
		cfg_index <= itp_pkg::REG_SIGNED;
		cfg_wdata <= {{(itp_pkg::RADIX_W-1){1'b0}}, sgn};
		shadow_signed = sgn;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin : feed_chars
		text_byte_t w;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				pending_results.push_back(next_parse_result(in_ch.start_req, in_ch.char_code));
			if (!drv_valid || in_ch.ready) begin
				if (char_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
					w = char_queue.pop_front();
					drv_valid <= 1'b1;
					drv_start <= w.start;
					drv_char <= w.code;
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			rx_ready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin : check_results
		parse_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word: value %h offset %0d finished %0b",
					$time, out_ch.value, out_ch.end_offset, out_ch.finished);
			end else begin
				want = pending_results.pop_front();
				if (out_ch.value !== want.value) begin
					errors++;
					$display("%0t: value expected %h got %h", $time, want.value, out_ch.value);
				end
				if (out_ch.end_offset !== want.end_offset) begin
					errors++;
					$display("%0t: end_offset expected %0d got %0d",
						$time, want.end_offset, out_ch.end_offset);
				end
				if (out_ch.finished !== want.finished) begin
					errors++;
					$display("%0t: finished expected %0b got %0b",
						$time, want.finished, out_ch.finished);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("integer_text_parser_test: done, errors");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int radix_plan[8] = '{0, 16, 10, 8, 2, 1, 36, 63};
		logic [itp_pkg::RADIX_W-1:0] rdx;
		logic sgn;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Auto base, signed: blanks around the sign, hex prefix, hex digits in both
		// letter cases, terminator, then a byte that is ignored after the stop.
		write_regs(itp_pkg::BASE_AUTO, 1'b1);
		next_start = 1'b1;
		put_text("\t-\n+0xfF");
		put_char(CH_NUL);
		put_text("z");
		// Prefix with no hex digit behind it, then octal after a leading zero.
		next_start = 1'b1;
		put_text("0Xg");
		next_start = 1'b1;
		put_text("078");
		drain_results();
		// Base one takes only zeros.
		write_regs(6'd1, 1'b0);
		next_start = 1'b1;
		put_text(" +001");
		drain_results();
		// A minus taken in signed mode stays in force after the registers change.
		write_regs(6'd63, 1'b1);
		next_start = 1'b1;
		put_text("-");
		drain_results();
		write_regs(itp_pkg::BASE_DEC, 1'b0);
		put_text("99");
		put_char(8'hFF);
		drain_results();

		for (int p = 0; p < 10; p++) begin
			rdx = (p < 8) ? itp_pkg::RADIX_W'(radix_plan[p]) :
				itp_pkg::RADIX_W'($urandom_range(63));
			sgn = (p < 8) ? p[0] : 1'($urandom_range(1));
			idle_pct = (p == 5) ? 0 : IDLE_PCT;
			write_regs(rdx, sgn);
			while (char_queue.size() < 70)
				add_number(rdx, sgn);
			drain_results();
		end

		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("integer_text_parser_test: done, clean");
		else
			$display("integer_text_parser_test: done, errors");
		$finish;
	end

endmodule

>>> filelist.f
design/itp_pkg.sv
design/itp_if.sv
design/itp_char_class.sv
design/itp_parser.sv
design/integer_text_parser.sv
tb/sv/integer_text_parser_test.sv
